// ----- hw/rtl/avosv_pkg.sv -----
// ----------------------------------------------------------------------------
// avosv_pkg
// Shared types and constants of the AV1 OBU stream validator.
// ----------------------------------------------------------------------------
package avosv_pkg;

	// default longest LEB128 size field in bytes
	localparam int MAX_SIZE_BYTES_DEF = 10;
	// payload bits carried by one LEB128 byte
	localparam int LEB_BITS = 7;
	// widest size accumulator
	localparam int ACC_W_MAX = 64;
	localparam int CNT_W = 32;
	localparam int STATUS_W = 3;
	// OBU type of a sequence header
	localparam logic [3:0] OBU_SEQ_HEADER = 4'd1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_FORBIDDEN   = 3'd1,
		ST_NO_SIZE     = 3'd2,
		ST_TRUNC_EXT   = 3'd3,
		ST_BAD_LEB     = 3'd4,
		ST_OVERRUN     = 3'd5
	} status_t;

	typedef enum logic [5:0] {
		PH_HEADER  = 6'b000001,
		PH_EXT     = 6'b000010,
		PH_SIZE    = 6'b000100,
		PH_PAYLOAD = 6'b001000,
		PH_ZEROS   = 6'b010000,
		PH_DRAIN   = 6'b100000
	} phase_t;

	// one input beat
	typedef struct packed {
		logic       fin;
		logic [7:0] data_byte;
	} in_beat_t;

	// one result beat
	typedef struct packed {
		logic [CNT_W-1:0] seq_header_total;
		logic [CNT_W-1:0] obu_total;
		status_t          status;
	} result_t;

endpackage

// ----- hw/rtl/av1_obu_stream_validator_top.sv -----
// ----------------------------------------------------------------------------
// av1_obu_stream_validator_top
// AV1 low-overhead OBU stream checker with LEB128 size parsing.
// ----------------------------------------------------------------------------
// a final byte's report passes the input register, then the result register, to m_tdata
// throughput: one byte per cycle, one parser step each, unless a final byte stalls for
// the result register, which lets the next stream start while a report waits
// reset: arst_n clears all control state; the parser starts at an OBU header
module av1_obu_stream_validator_top
	import avosv_pkg::*;
#(
	parameter int MAX_SIZE_BYTES = MAX_SIZE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tlast,   // is_final
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // status[2:0], obu_total[34:3], seq_header_total[66:35]
);

	in_beat_t in_beat, beat_s1;
	logic     valid_s1, consume, res_valid, out_room;
	result_t  res, res_q;
	logic     out_valid_q;

	assign in_beat.data_byte = s_tdata;
	assign in_beat.fin       = s_tlast;

	avosv_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_beat  (in_beat),
		.consume  (consume),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	avosv_parser #(
		.MAX_SIZE_BYTES (MAX_SIZE_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.beat_s1   (beat_s1),
		.out_room  (out_room),
		.consume   (consume),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register
	assign out_room = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_room) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, res_q};

endmodule

// ----- hw/rtl/avosv_in_stage.sv -----
// ----------------------------------------------------------------------------
// avosv_in_stage
// Input register: holds one byte beat until the parser consumes it.
// ----------------------------------------------------------------------------
module avosv_in_stage
	import avosv_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_beat_t in_beat,
	input  logic     consume,
	output logic     valid_s1,
	output in_beat_t beat_s1
);

	// take a new beat when empty or when the held one leaves this cycle
	assign in_ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_s1 <= in_beat;
		end
	end

endmodule

// ----- hw/rtl/avosv_parser.sv -----
// ----------------------------------------------------------------------------
// avosv_parser
// OBU header / LEB128 size / payload skip state, error latch and counters.
// ----------------------------------------------------------------------------
module avosv_parser
	import avosv_pkg::*;
#(
	parameter int MAX_SIZE_BYTES = MAX_SIZE_BYTES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     valid_s1,
	input  in_beat_t beat_s1,
	input  logic     out_room,
	output logic     consume,
	output logic     res_valid,
	output result_t  res
);

	localparam int ACC_W   = (LEB_BITS * MAX_SIZE_BYTES > ACC_W_MAX) ?
		ACC_W_MAX : LEB_BITS * MAX_SIZE_BYTES;
	localparam int IDX_W   = $clog2(MAX_SIZE_BYTES + 1);
	localparam int SHIFT_W = (ACC_W > 1) ? $clog2(ACC_W) : 1;

	phase_t             phase_q, phase_n;
	status_t            err_q, err_n;
	logic [IDX_W-1:0]   idx_q, idx_n, idx_inc;
	logic [3:0]         type_q, type_n;
	logic [ACC_W-1:0]   acc_q, acc_n, acc_new;
	logic [ACC_W-1:0]   pay_q, pay_n, pay_dec;
	logic [CNT_W-1:0]   obu_q, obu_n, seq_q, seq_n;
	logic [SHIFT_W-1:0] shift;
	logic [7:0]         b;
	logic               fin;

	// a final beat needs room in the output register
	assign consume   = valid_s1 && (!beat_s1.fin || out_room);
	assign res_valid = consume && beat_s1.fin;

	assign b       = beat_s1.data_byte;
	assign fin     = beat_s1.fin;
	assign idx_inc = idx_q + IDX_W'(1);
	assign shift   = SHIFT_W'(idx_q * LEB_BITS);
	assign acc_new = acc_q | (ACC_W'(b[6:0]) << shift);
	assign pay_dec = pay_q - ACC_W'(1);

	// next state for the held byte
	always_comb begin
		phase_n = phase_q;
		err_n   = err_q;
		idx_n   = idx_q;
		type_n  = type_q;
		acc_n   = acc_q;
		pay_n   = pay_q;
		obu_n   = obu_q;
		seq_n   = seq_q;
		case (phase_q)
			PH_HEADER: begin
				if (b == 8'd0) begin
					phase_n = PH_ZEROS;
				end else if (b[7]) begin
					phase_n = PH_DRAIN;
					err_n   = ST_FORBIDDEN;
				end else if (!b[1]) begin
					phase_n = PH_DRAIN;
					err_n   = ST_NO_SIZE;
				end else begin
					type_n = b[6:3];
					acc_n  = '0;
					idx_n  = '0;
					if (b[2]) begin
						phase_n = fin ? PH_DRAIN : PH_EXT;
						if (fin) err_n = ST_TRUNC_EXT;
					end else begin
						phase_n = fin ? PH_DRAIN : PH_SIZE;
						if (fin) err_n = ST_BAD_LEB;
					end
				end
			end
			PH_EXT: begin
				phase_n = fin ? PH_DRAIN : PH_SIZE;
				if (fin) err_n = ST_BAD_LEB;
			end
			PH_SIZE: begin
				acc_n = acc_new;
				idx_n = idx_inc;
				if (b[7]) begin
					if (idx_inc >= IDX_W'(MAX_SIZE_BYTES) || fin) begin
						phase_n = PH_DRAIN;
						err_n   = ST_BAD_LEB;
					end
				end else begin
					pay_n = acc_new;
					if (acc_new == '0) begin
						phase_n = PH_HEADER;
						if (obu_q != '1) obu_n = obu_q + CNT_W'(1);
						if (type_q == OBU_SEQ_HEADER && seq_q != '1) seq_n = seq_q + CNT_W'(1);
					end else begin
						phase_n = fin ? PH_DRAIN : PH_PAYLOAD;
						if (fin) err_n = ST_OVERRUN;
					end
				end
			end
			PH_PAYLOAD: begin
				pay_n = pay_dec;
				if (pay_dec == '0) begin
					phase_n = PH_HEADER;
					if (obu_q != '1) obu_n = obu_q + CNT_W'(1);
					if (type_q == OBU_SEQ_HEADER && seq_q != '1) seq_n = seq_q + CNT_W'(1);
				end else if (fin) begin
					phase_n = PH_DRAIN;
					err_n   = ST_OVERRUN;
				end
			end
			PH_ZEROS: begin
				if (b != 8'd0) begin
					phase_n = PH_DRAIN;
					err_n   = ST_NO_SIZE;
				end
			end
			default: begin
				phase_n = PH_DRAIN;
			end
		endcase
	end

	// report after the final byte
	always_comb begin
		res.status           = err_n;
		res.obu_total        = obu_n;
		res.seq_header_total = seq_n;
	end

	// control state, cleared after each final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			err_q   <= ST_OK;
			idx_q   <= '0;
			type_q  <= '0;
			obu_q   <= '0;
			seq_q   <= '0;
		end else if (consume) begin
			if (fin) begin
				phase_q <= PH_HEADER;
				err_q   <= ST_OK;
				idx_q   <= '0;
				type_q  <= '0;
				obu_q   <= '0;
				seq_q   <= '0;
			end else begin
				phase_q <= phase_n;
				err_q   <= err_n;
				idx_q   <= idx_n;
				type_q  <= type_n;
				obu_q   <= obu_n;
				seq_q   <= seq_n;
			end
		end
	end

	// size accumulator and payload down-counter
	always_ff @(posedge clk) begin
		if (consume) begin
			acc_q <= acc_n;
			pay_q <= pay_n;
		end
	end

endmodule
